// ----- rtl/sip_rng_pkg.sv -----
// Package: SipHash constants, command/status structs and shared types.
package sip_rng_pkg;

   localparam logic [63:0] KEY0 = 64'h0807060504030201;
   localparam logic [63:0] KEY1 = 64'h000F0E0D0C0B0A09;
   localparam logic [63:0] IV0 = 64'h736f6d6570736575;
   localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
   localparam logic [63:0] IV2 = 64'h6c7967656e657261;
   localparam logic [63:0] IV3 = 64'h7465646279746573;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic [1:0] CSR_SEED = 2'd0;
   localparam logic [1:0] CSR_STREAM = 2'd1;
   localparam logic [1:0] CSR_CHANNEL = 2'd2;
   localparam logic [1:0] CSR_MODE = 2'd3;

   // message word selects
   localparam logic [2:0] MSG_SEED = 3'd0;
   localparam logic [2:0] MSG_STREAM = 3'd1;
   localparam logic [2:0] MSG_CHANNEL = 3'd2;
   localparam logic [2:0] MSG_COUNTER = 3'd3;
   localparam logic [2:0] MSG_LENGTH = 3'd4;

   typedef struct packed {
      logic       load_req;   // capture request fields, size and range flags
      logic       hash_init;  // load v with key^IV
      logic       absorb_pre; // v3 ^= m
      logic       absorb_post;// v0 ^= m
      logic       fin_pre;    // v2 ^= ff
      logic       round;      // one SipRound
      logic [2:0] msg_sel;
      logic       cnt_inc;
      logic       div_start;  // start modulo of draw by size
      logic       rem_start;  // start modulo of all-ones by size
      logic       load_raw;   // result = hash
      logic       load_lo;    // result = range_low
      logic       load_mod;   // result = lo + mod
   } sip_cmd_type;

   typedef struct packed {
      logic req_range;
      logic degenerate;  // hi <= lo
      logic full_range;  // size wrapped to zero
      logic reject;      // hash >= limit
      logic div_busy;
   } sip_sts_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
      rotl = (x << r) | (x >> (64 - r));
   endfunction

endpackage

// ----- rtl/sip_rng_div.sv -----
// Iterative restoring 64-bit unsigned modulo, one bit per cycle.
module sip_rng_div
   import sip_rng_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        busy,
   output logic [63:0] remainder
);
   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] shifted;
   logic [64:0] diff;

   always_comb begin
      shifted = {rem_ff[63:0], quo_ff[63]};
      diff = shifted - {1'b0, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], 1'b0};
         rem_in = diff[64] ? shifted : diff;
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign remainder = rem_ff[63:0];

`ifndef SYNTHESIS
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && !start |=> !busy_ff) else $error("div busy without start");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) && !$past(start) |-> rem_ff[63:0] < dvs_ff)
      else $error("remainder not below divisor");
   a_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff == 7'd1 && !start |=> !busy_ff)
      else $error("div did not finish");
`endif
endmodule

// ----- rtl/sip_rng_dp.sv -----
// Datapath: SipHash state, config registers, counter, range arithmetic.
module sip_rng_dp
   import sip_rng_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_type,
   input  logic [63:0] req_range_low,
   input  logic [63:0] req_range_high,
   input  sip_cmd_type cmd,
   output sip_sts_type sts,
   output logic        chan_mode,
   output logic [63:0] result
);
   logic [63:0] seed_ff, stream_ff, chan_ff;
   logic        mode_ff;
   logic [63:0] cnt_ff;
   logic [63:0] v0_ff, v1_ff, v2_ff, v3_ff;
   logic [63:0] v0_in, v1_in, v2_in, v3_in;
   logic [63:0] lo_ff, size_ff, limit_ff, res_ff;
   logic        rtype_ff, degen_ff, full_ff;
   logic [63:0] msg;
   logic [63:0] hash;
   logic [63:0] a0, a1, a2, a3, b0, b1, b2, b3;
   logic        div_start;
   logic [63:0] div_num;
   logic        div_busy;
   logic [63:0] div_rem;
   logic [63:0] size_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         stream_ff <= '0;
         chan_ff <= '0;
         mode_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SEED:    seed_ff <= csr_data;
               CSR_STREAM:  stream_ff <= csr_data;
               CSR_CHANNEL: chan_ff <= csr_data;
               CSR_MODE:    mode_ff <= csr_data[0];
               default:     ;
            endcase
         end
         if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + 64'd1;
         end
      end
   end

   always_comb begin
      unique case (cmd.msg_sel)
         MSG_SEED:    msg = seed_ff;
         MSG_STREAM:  msg = stream_ff;
         MSG_CHANNEL: msg = chan_ff;
         MSG_COUNTER: msg = cnt_ff;
         MSG_LENGTH:  msg = mode_ff ? {8'd32, 56'd0} : {8'd24, 56'd0};
         default:     msg = '0;
      endcase
   end

   // one SipRound
   always_comb begin
      a0 = v0_ff + v1_ff;
      a1 = rotl(v1_ff, 13) ^ a0;
      a0 = rotl(a0, 32);
      a2 = v2_ff + v3_ff;
      a3 = rotl(v3_ff, 16) ^ a2;
      b0 = a0 + a3;
      b3 = rotl(a3, 21) ^ b0;
      b2 = a2 + a1;
      b1 = rotl(a1, 17) ^ b2;
      b2 = rotl(b2, 32);
   end

   always_comb begin
      v0_in = v0_ff;
      v1_in = v1_ff;
      v2_in = v2_ff;
      v3_in = v3_ff;
      if (cmd.hash_init) begin
         v0_in = KEY0 ^ IV0;
         v1_in = KEY1 ^ IV1;
         v2_in = KEY0 ^ IV2;
         v3_in = KEY1 ^ IV3;
      end else if (cmd.absorb_pre) begin
         v3_in = v3_ff ^ msg;
      end else if (cmd.absorb_post) begin
         v0_in = v0_ff ^ msg;
      end else if (cmd.fin_pre) begin
         v2_in = v2_ff ^ 64'h00000000000000FF;
      end else if (cmd.round) begin
         v0_in = b0;
         v1_in = b1;
         v2_in = b2;
         v3_in = b3;
      end
   end

   assign hash = v0_ff ^ v1_ff ^ v2_ff ^ v3_ff;
   assign size_w = req_range_high - req_range_low + 64'd1;

   always_ff @(posedge clock) begin
      v0_ff <= v0_in;
      v1_ff <= v1_in;
      v2_ff <= v2_in;
      v3_ff <= v3_in;
      if (cmd.load_req) begin
         rtype_ff <= req_type;
         lo_ff <= req_range_low;
         size_ff <= size_w;
         degen_ff <= req_range_high <= req_range_low;
         full_ff <= size_w == 64'd0;
      end
      if (cmd.load_raw) begin
         res_ff <= hash;
      end else if (cmd.load_lo) begin
         res_ff <= lo_ff;
      end else if (cmd.load_mod) begin
         res_ff <= lo_ff + div_rem;
      end else if (cmd.div_start) begin
         // result is held; in ST_LIMIT the rem of all-ones is ready here
         res_ff <= res_ff;
      end
      // limit = all-ones minus (all-ones mod size)
      if (cmd.div_start && cmd.rem_start) begin
         limit_ff <= ALL_ONES - div_rem;
      end
   end

   assign div_start = cmd.rem_start ^ cmd.div_start;
   assign div_num = cmd.rem_start ? ALL_ONES : hash;

   sip_rng_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (size_ff),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   assign sts.req_range = rtype_ff;
   assign sts.degenerate = degen_ff;
   assign sts.full_range = full_ff;
   assign sts.reject = hash >= limit_ff;
   assign sts.div_busy = div_busy;
   assign chan_mode = mode_ff;
   assign result = res_ff;
endmodule

// ----- rtl/sip_rng_ctrl.sv -----
// Controller: sequences hashing, rejection loop and modulo steps.
module sip_rng_ctrl
   import sip_rng_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        chan_mode,
   input  sip_sts_type sts,
   output sip_cmd_type cmd
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DECIDE = 4'd1;
   localparam logic [3:0] ST_REM = 4'd2;
   localparam logic [3:0] ST_LIMIT = 4'd3;
   localparam logic [3:0] ST_INIT = 4'd4;
   localparam logic [3:0] ST_PRE = 4'd5;
   localparam logic [3:0] ST_ROUND = 4'd6;
   localparam logic [3:0] ST_POST = 4'd7;
   localparam logic [3:0] ST_FIN = 4'd8;
   localparam logic [3:0] ST_CHECK = 4'd9;
   localparam logic [3:0] ST_MOD = 4'd10;
   localparam logic [3:0] ST_ADD = 4'd11;
   localparam logic [3:0] ST_OUT = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [2:0] word_ff, word_in;  // message word in progress
   logic [1:0] rnd_ff, rnd_in;
   logic       fin_ff, fin_in;    // in finalization rounds
   logic       out_ff, out_in;
   logic [2:0] next_word;

   always_comb begin
      unique case (word_ff)
         MSG_SEED:    next_word = MSG_STREAM;
         MSG_STREAM:  next_word = chan_mode ? MSG_CHANNEL : MSG_COUNTER;
         MSG_CHANNEL: next_word = MSG_COUNTER;
         default:     next_word = MSG_LENGTH;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.msg_sel = word_ff;
      state_in = state_ff;
      word_in = word_ff;
      rnd_in = rnd_ff;
      fin_in = fin_ff;
      out_in = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // an empty range answers low even when its size wraps to zero
            if (sts.req_range && sts.degenerate) begin
               cmd.load_lo = 1'b1;
               state_in = ST_OUT;
            end else if (!sts.req_range || sts.full_range) begin
               state_in = ST_INIT;
            end else begin
               cmd.rem_start = 1'b1;
               state_in = ST_REM;
            end
         end
         ST_REM: begin
            if (!sts.div_busy) begin
               state_in = ST_LIMIT;
            end
         end
         ST_LIMIT: begin
            cmd.rem_start = 1'b1;
            cmd.div_start = 1'b1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.hash_init = 1'b1;
            word_in = MSG_SEED;
            fin_in = 1'b0;
            state_in = ST_PRE;
         end
         ST_PRE: begin
            cmd.absorb_pre = 1'b1;
            rnd_in = 2'd2;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            rnd_in = rnd_ff - 2'd1;
            if (fin_ff ? (rnd_ff == 2'd0) : (rnd_ff == 2'd1)) begin
               state_in = fin_ff ? ST_CHECK : ST_POST;
            end
         end
         ST_POST: begin
            cmd.absorb_post = 1'b1;
            if (word_ff == MSG_COUNTER) begin
               cmd.cnt_inc = 1'b1;
            end
            if (word_ff == MSG_LENGTH) begin
               state_in = ST_FIN;
            end else begin
               word_in = next_word;
               state_in = ST_PRE;
            end
         end
         ST_FIN: begin
            cmd.fin_pre = 1'b1;
            fin_in = 1'b1;
            rnd_in = 2'd3;
            state_in = ST_ROUND;
         end
         ST_CHECK: begin
            if (!sts.req_range || sts.full_range) begin
               cmd.load_raw = 1'b1;
               state_in = ST_OUT;
            end else if (sts.reject) begin
               state_in = ST_INIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (!sts.div_busy) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.load_mod = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            out_in = 1'b1;
            state_in = ST_OUT;
            if (out_ff && rsp_ready) begin
               out_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rnd_ff <= rnd_in;
      fin_ff <= fin_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = out_ff;

`ifndef SYNTHESIS
   a_out_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_OUT) else $error("rsp_valid outside output");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
`endif
endmodule

// ----- rtl/siphash_counter_rng_range.sv -----
// Top level: SipHash-2-4 counter-based generator with range draws.
//  channel | handshake              | payload
//  req     | req_valid/req_ready    | req_type, req_range_low, req_range_high
//  rsp     | rsp_valid/rsp_ready    | rsp_value
//  csr     | csr_valid/csr_ready    | csr_index, csr_data
// A raw draw runs its message words (3 words, 4 with the channel word) through the
// single shared SipRound unit. A range draw adds the limit modulo, then per
// accepted draw the final modulo; each rejection repeats the hash and check.
// Degenerate ranges answer low without hashing. Reset is synchronous and clears
// the config registers, counter and control state. One item at a time; a held
// result stalls intake.
module siphash_counter_rng_range
   import sip_rng_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [63:0] req_range_low,
   input  logic [63:0] req_range_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   sip_cmd_type cmd;
   sip_sts_type sts;
   logic        chan_mode;

   assign csr_ready = 1'b1;

   sip_rng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .chan_mode (chan_mode),
      .sts       (sts),
      .cmd       (cmd)
   );

   sip_rng_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_type       (req_type),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .cmd            (cmd),
      .sts            (sts),
      .chan_mode      (chan_mode),
      .result         (rsp_value)
   );
endmodule
